// ----- rtl/superblock_hilbert_fragment_addresser_macros.svh -----
// assertion helpers for the rtl
`ifndef SUPERBLOCK_HILBERT_FRAGMENT_ADDRESSER_MACROS_SVH
`define SUPERBLOCK_HILBERT_FRAGMENT_ADDRESSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBHFA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBHFA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sbhfa_pkg.sv -----
package sbhfa_pkg;

    localparam int DIM_W      = 12;
    localparam int PAD_EXTRA  = 64;
    localparam int BORDER     = 32;
    localparam int RST_WIDTH  = 352;
    localparam int RST_HEIGHT = 288;

    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_CB   = 2'd1;
    localparam logic [1:0] PLANE_CR   = 2'd2;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [1:0] HIL16_X [16] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3};
    localparam logic [1:0] HIL16_Y [16] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2,
                                            2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
    localparam logic HIL4_X [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
    localparam logic HIL4_Y [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

    typedef struct packed {
        logic [1:0] plane;
        logic [6:0] sb_row;
        logic [6:0] sb_col;
        logic [3:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [18:0] frag_index;
        logic        frag_valid;
        logic [24:0] buffer_offset;
        logic [16:0] mb_index;
        logic        mb_valid;
    } out_item_t;

    // frame geometry, one struct per derivation level
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } geom0_t;

    typedef struct packed {
        logic [12:0] stride_y;
        logic [11:0] stride_c;
        logic [12:0] height_pad;
        logic [8:0]  fh0;
        logic [8:0]  fv0;
        logic [7:0]  fh1;
        logic [7:0]  fv1;
    } geom1_t;

    typedef struct packed {
        logic [24:0] size_y;
        logic [17:0] first1;
        logic [15:0] frag_c;
        logic [17:0] base0;
        logic [15:0] cbase;
    } geom2_t;

    typedef struct packed {
        logic [17:0] first1;
        logic [18:0] first2;
        logic [18:0] frag_count;
        logic [15:0] mb_total;
        logic [17:0] base0;
        logic [24:0] base1;
        logic [24:0] base2;
    } geom3_t;

endpackage

// ----- rtl/sbhfa_geom.sv -----
module sbhfa_geom (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  sbhfa_pkg::cfg_reg_t        cfg_index,
    input  logic [sbhfa_pkg::DIM_W-1:0] cfg_data,
    output sbhfa_pkg::geom0_t          g0,
    output sbhfa_pkg::geom1_t          g1,
    output sbhfa_pkg::geom3_t          g3
);
    import sbhfa_pkg::*;

    localparam int RST_SY     = RST_WIDTH + PAD_EXTRA;
    localparam int RST_HP     = RST_HEIGHT + PAD_EXTRA;
    localparam int RST_SC     = RST_SY / 2;
    localparam int RST_FH0    = RST_WIDTH / 8;
    localparam int RST_FV0    = RST_HEIGHT / 8;
    localparam int RST_FH1    = RST_WIDTH / 16;
    localparam int RST_FV1    = RST_HEIGHT / 16;
    localparam int RST_SIZE   = RST_SY * RST_HP;
    localparam int RST_FIRST1 = RST_FH0 * RST_FV0;
    localparam int RST_FRAGC  = RST_FH1 * RST_FV1;
    localparam int RST_BASE0  = RST_SY * BORDER + BORDER;
    localparam int RST_CBASE  = RST_SC * (BORDER / 2) + BORDER / 2;
    localparam int RST_FIRST2 = RST_FIRST1 + RST_FRAGC;
    localparam int RST_TOTAL  = RST_FIRST2 + RST_FRAGC;
    localparam int RST_BASE1  = RST_SIZE + RST_CBASE;
    localparam int RST_BASE2  = RST_SIZE + RST_SIZE / 4 + RST_CBASE;

    geom0_t g0_reg;
    geom1_t g1_reg;
    geom1_t g1_next;
    geom2_t g2_reg;
    geom2_t g2_next;
    geom3_t g3_reg;
    geom3_t g3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g0_reg.width  <= DIM_W'(RST_WIDTH);
            g0_reg.height <= DIM_W'(RST_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  g0_reg.width  <= cfg_data;
                REG_FRAME_HEIGHT: g0_reg.height <= cfg_data;
                default:          g0_reg        <= g0_reg;
            endcase
        end
    end

    always_comb
    begin
        g1_next.stride_y   = 13'(g0_reg.width) + 13'(PAD_EXTRA);
        g1_next.stride_c   = g1_next.stride_y[12:1];
        g1_next.height_pad = 13'(g0_reg.height) + 13'(PAD_EXTRA);
        g1_next.fh0        = g0_reg.width[11:3];
        g1_next.fv0        = g0_reg.height[11:3];
        g1_next.fh1        = g0_reg.width[11:4];
        g1_next.fv1        = g0_reg.height[11:4];
    end

    always_comb
    begin
        g2_next.size_y = 25'(g1_reg.stride_y) * 25'(g1_reg.height_pad);
        g2_next.first1 = 18'(g1_reg.fh0) * 18'(g1_reg.fv0);
        g2_next.frag_c = 16'(g1_reg.fh1) * 16'(g1_reg.fv1);
        g2_next.base0  = 18'(g1_reg.stride_y) * 18'(BORDER) + 18'(BORDER);
        g2_next.cbase  = 16'(g1_reg.stride_c) * 16'(BORDER / 2) + 16'(BORDER / 2);
    end

    always_comb
    begin
        g3_next.first1     = g2_reg.first1;
        g3_next.first2     = 19'(g2_reg.first1) + 19'(g2_reg.frag_c);
        g3_next.frag_count = 19'(g2_reg.first1) + 19'(g2_reg.frag_c) + 19'(g2_reg.frag_c);
        g3_next.mb_total   = g2_reg.frag_c;
        g3_next.base0      = g2_reg.base0;
        g3_next.base1      = g2_reg.size_y + 25'(g2_reg.cbase);
        g3_next.base2      = g2_reg.size_y + (g2_reg.size_y >> 2) + 25'(g2_reg.cbase);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg <= '{stride_y: 13'(RST_SY), stride_c: 12'(RST_SC),
                        height_pad: 13'(RST_HP), fh0: 9'(RST_FH0), fv0: 9'(RST_FV0),
                        fh1: 8'(RST_FH1), fv1: 8'(RST_FV1)};
            g2_reg <= '{size_y: 25'(RST_SIZE), first1: 18'(RST_FIRST1),
                        frag_c: 16'(RST_FRAGC), base0: 18'(RST_BASE0),
                        cbase: 16'(RST_CBASE)};
            g3_reg <= '{first1: 18'(RST_FIRST1), first2: 19'(RST_FIRST2),
                        frag_count: 19'(RST_TOTAL), mb_total: 16'(RST_FRAGC),
                        base0: 18'(RST_BASE0), base1: 25'(RST_BASE1),
                        base2: 25'(RST_BASE2)};
        end
        else
        begin
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            g3_reg <= g3_next;
        end
    end

    assign g0 = g0_reg;
    assign g1 = g1_reg;
    assign g3 = g3_reg;

endmodule

// ----- rtl/superblock_hilbert_fragment_addresser.sv -----
// Superblock Hilbert-order fragment addresser.
// Input channel in_valid / in_stall / in_data carries (plane, sb_row, sb_col, slot);
// output channel out_valid / out_stall / out_data carries the fragment index, its
// buffer offset and the macroblock index with their valid flags. A transaction
// completes on a clock edge where valid is high and stall is low.
// Frame width and height are written through cfg_we / cfg_index / cfg_data while
// the block is idle; derived geometry is registered through g1, g2 and g3 in turn,
// in step with the first transaction that can use it.
// An input transaction reaches out_valid through four register stages (hilbert
// position and bounds, the three multipliers, the adders, the final base and
// select). Throughput is one transaction per cycle while out_stall is low.
// When the receiver stalls, the output register holds and stall moves back stage
// by stage; empty stages still fill, so in_stall rises only once all four stages
// hold a transaction. Nothing is dropped or repeated.
// Reset clears the valid flag of every stage and sets the frame to 352 x 288.
`include "superblock_hilbert_fragment_addresser_macros.svh"

module superblock_hilbert_fragment_addresser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  sbhfa_pkg::cfg_reg_t         cfg_index,
    input  logic [sbhfa_pkg::DIM_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sbhfa_pkg::in_item_t         in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sbhfa_pkg::out_item_t        out_data
);
    import sbhfa_pkg::*;

    typedef struct packed {
        logic [1:0] plane;
        logic [8:0] fr;
        logic [8:0] fc;
        logic [7:0] mr;
        logic [7:0] mc;
        logic       frag_in;
        logic       mb_in;
    } s1_t;

    typedef struct packed {
        logic [1:0]  plane;
        logic [17:0] fprod;
        logic [21:0] rprod;
        logic [15:0] mprod;
        logic [8:0]  fc;
        logic [7:0]  mc;
        logic        frag_in;
        logic        mb_in;
    } s2_t;

    typedef struct packed {
        logic [1:0]  plane;
        logic [18:0] fsum;
        logic [24:0] osum;
        logic [15:0] msum;
        logic        frag_in;
        logic        mb_in;
    } s3_t;

    geom0_t g0;
    geom1_t g1;
    geom3_t g3;

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      adv1, adv2, adv3, adv4;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    out_item_t s4_reg, s4_next;

    sbhfa_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .g0        (g0),
        .g1        (g1),
        .g3        (g3)
    );

    assign adv4     = !v4_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    // hilbert position and bounds, straight from the frame size registers
    always_comb
    begin
        logic       is_luma;
        logic       plane_ok;
        logic [7:0] sel_sh;
        logic [7:0] sel_sv;
        logic [8:0] sel_fh;
        logic [8:0] sel_fv;
        logic [7:0] mb_h;
        logic [7:0] mb_v;
        logic [8:0] mr9;
        logic [8:0] mc9;
        logic       have;
        logic       in_sb;

        is_luma  = (in_data.plane == PLANE_LUMA);
        plane_ok = is_luma || (in_data.plane == PLANE_CB) || (in_data.plane == PLANE_CR);
        mb_h     = g0.width[11:4];
        mb_v     = g0.height[11:4];
        if (is_luma)
        begin
            sel_sh = 8'(g0.width[11:5]) + 8'(|g0.width[4:0]);
            sel_sv = 8'(g0.height[11:5]) + 8'(|g0.height[4:0]);
            sel_fh = g0.width[11:3];
            sel_fv = g0.height[11:3];
        end
        else
        begin
            sel_sh = 8'(g0.width[11:6]) + 8'(|g0.width[5:0]);
            sel_sv = 8'(g0.height[11:6]) + 8'(|g0.height[5:0]);
            sel_fh = 9'(g0.width[11:4]);
            sel_fv = 9'(g0.height[11:4]);
        end

        s1_next.plane = in_data.plane;
        s1_next.fr    = {in_data.sb_row, 2'b00} + 9'(HIL16_Y[in_data.slot]);
        s1_next.fc    = {in_data.sb_col, 2'b00} + 9'(HIL16_X[in_data.slot]);

        if (is_luma)
        begin
            have = (in_data.slot[3:2] == 2'b00);
            mr9  = 9'({in_data.sb_row, 1'b0}) + 9'(HIL4_Y[in_data.slot[1:0]]);
            mc9  = 9'({in_data.sb_col, 1'b0}) + 9'(HIL4_X[in_data.slot[1:0]]);
        end
        else
        begin
            have = 1'b1;
            mr9  = s1_next.fr;
            mc9  = s1_next.fc;
        end

        in_sb = plane_ok && (8'(in_data.sb_row) < sel_sv) && (8'(in_data.sb_col) < sel_sh);
        s1_next.frag_in = in_sb && (s1_next.fr < sel_fv) && (s1_next.fc < sel_fh);
        s1_next.mb_in   = in_sb && have && (mr9 < 9'(mb_v)) && (mc9 < 9'(mb_h));
        s1_next.mr      = mr9[7:0];
        s1_next.mc      = mc9[7:0];
    end

    // row products
    always_comb
    begin
        logic [8:0]  fh_p;
        logic [12:0] stride_p;

        if (s1_reg.plane == PLANE_LUMA)
        begin
            fh_p     = g1.fh0;
            stride_p = g1.stride_y;
        end
        else
        begin
            fh_p     = 9'(g1.fh1);
            stride_p = 13'(g1.stride_c);
        end
        s2_next.plane   = s1_reg.plane;
        s2_next.fprod   = 18'(s1_reg.fr) * 18'(fh_p);
        s2_next.rprod   = 22'(s1_reg.fr) * 22'(stride_p);
        s2_next.mprod   = 16'(s1_reg.mr) * 16'(g1.fh1);
        s2_next.fc      = s1_reg.fc;
        s2_next.mc      = s1_reg.mc;
        s2_next.frag_in = s1_reg.frag_in;
        s2_next.mb_in   = s1_reg.mb_in;
    end

    // in-plane sums
    always_comb
    begin
        s3_next.plane   = s2_reg.plane;
        s3_next.fsum    = 19'(s2_reg.fprod) + 19'(s2_reg.fc);
        s3_next.osum    = {s2_reg.rprod, 3'b000} + 25'({s2_reg.fc, 3'b000});
        s3_next.msum    = s2_reg.mprod + 16'(s2_reg.mc);
        s3_next.frag_in = s2_reg.frag_in;
        s3_next.mb_in   = s2_reg.mb_in;
    end

    // plane bases and invalid marks
    always_comb
    begin
        logic [18:0] first_p;
        logic [24:0] base_p;

        case (s3_reg.plane)
            PLANE_CB:
            begin
                first_p = 19'(g3.first1);
                base_p  = g3.base1;
            end
            PLANE_CR:
            begin
                first_p = g3.first2;
                base_p  = g3.base2;
            end
            default:
            begin
                first_p = '0;
                base_p  = 25'(g3.base0);
            end
        endcase

        s4_next.frag_valid    = s3_reg.frag_in;
        s4_next.frag_index    = s3_reg.frag_in ? (s3_reg.fsum + first_p) : g3.frag_count;
        s4_next.buffer_offset = s3_reg.frag_in ? (s3_reg.osum + base_p) : '0;
        s4_next.mb_valid      = s3_reg.mb_in;
        s4_next.mb_index      = s3_reg.mb_in ? 17'(s3_reg.msum) : 17'(g3.mb_total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
        if (adv4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    `SBHFA_ASSERT_SAME(a_frag_below_total, out_valid && out_data.frag_valid,
        out_data.frag_index < g3.frag_count, "valid fragment index not below total")
    `SBHFA_ASSERT_SAME(a_offset_zero, out_valid && !out_data.frag_valid,
        out_data.buffer_offset == '0, "invalid fragment with nonzero offset")
    `SBHFA_ASSERT_SAME(a_mb_below_total, out_valid && out_data.mb_valid,
        out_data.mb_index < 17'(g3.mb_total), "valid macroblock index not below total")
    `SBHFA_ASSERT_NEXT(a_stage3_holds, v3_reg && !adv4,
        v3_reg && $stable(s3_reg), "stalled stage lost its transaction")

endmodule
